[rtl/ccl_pkg.sv]
// shared constants, widths, register indexes and types for the
// cross-channel lrn forward core; no dependencies
`default_nettype none

package ccl_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF  = 15;

    localparam int SUM_W      = 36;
    localparam int SCALE_W    = 16;
    localparam int EXP_W      = 10;
    localparam int WS_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int D_W        = 53;
    localparam int D_ONE_POS  = 32;
    localparam int FRAC_W     = 16;
    localparam int LG_INT_W   = 5;
    localparam int LG_W       = LG_INT_W + FRAC_W;
    localparam int T_SHIFT    = 8;
    localparam int T_W        = 23;
    localparam int TI_W       = T_W - FRAC_W;
    localparam int Y_W        = 17;
    localparam int Y_ZERO_SHIFT = 17;
    localparam int Y_SHIFT_W  = 5;

    localparam int LZ_STEPS   = 5;
    localparam int LZ_CNT_W   = 5;
    localparam int LZ_STEP_W  = 3;

    localparam int WS_RESET    = 5;
    localparam int SCALE_RESET = 13;
    localparam int EXP_RESET   = 192;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT    = 2'd2;

    typedef enum logic [1:0] {
        MUL_SQUARE,
        MUL_SCALE,
        MUL_EXP,
        MUL_MAG
    } mul_op_t;

    typedef struct packed {
        logic           load;
        logic [D_W-1:0] d;
    } lz_ctl_t;

    typedef struct packed {
        logic            done;
        logic [LG_W-1:0] lg;
    } lz_stat_t;

endpackage

`default_nettype wire

[rtl/ccl_cfg_if.sv]
// configuration write channel: register index and write data
// depends on ccl_pkg
`default_nettype none

interface ccl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ccl_pkg::CFG_IDX_W-1:0]   index;
    logic [ccl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/ccl_feed_if.sv]
// input channel: one channel sample per beat with last-channel mark
// depends on ccl_pkg
`default_nettype none

interface ccl_feed_if #(
    parameter int SAMPLE_BITS = ccl_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_channel;

    modport source (output valid, output sample, output last_channel, input ready);
    modport sink (input valid, input sample, input last_channel, output ready);
endinterface

`default_nettype wire

[rtl/ccl_result_if.sv]
// output channel: one normalized sample per beat with last mark
// depends on ccl_pkg
`default_nettype none

interface ccl_result_if #(
    parameter int SAMPLE_BITS = ccl_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] normalized;
    logic                          last;

    modport source (output valid, output normalized, output last, input ready);
    modport sink (input valid, input normalized, input last, output ready);
endinterface

`default_nettype wire

[rtl/ccl_mul_unit.sv]
// shared multiplier with operand selection for squares, scaling,
// exponent product and final magnitude scaling; depends on ccl_pkg
`default_nettype none

module ccl_mul_unit #(
    parameter int SAMPLE_BITS = ccl_pkg::SAMPLE_BITS_DEF,
    localparam int A_W = (SAMPLE_BITS > ccl_pkg::SUM_W) ? SAMPLE_BITS : ccl_pkg::SUM_W,
    localparam int B_W = (SAMPLE_BITS > ccl_pkg::Y_W) ? SAMPLE_BITS : ccl_pkg::Y_W,
    localparam int P_W = A_W + B_W
) (
    input  ccl_pkg::mul_op_t               op,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [ccl_pkg::SUM_W-1:0]      sum,
    input  logic [ccl_pkg::SCALE_W-1:0]    scale,
    input  logic [ccl_pkg::EXP_W-1:0]      exponent,
    input  logic [ccl_pkg::LG_W-1:0]       lg,
    input  logic [ccl_pkg::Y_W-1:0]        y,
    output logic [P_W-1:0]                 product
);

    logic [SAMPLE_BITS-1:0] mag;
    logic [A_W-1:0]         op_a;
    logic [B_W-1:0]         op_b;

    assign mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

    always_comb
    begin
        case (op)
            ccl_pkg::MUL_SQUARE:
            begin
                op_a = A_W'(mag);
                op_b = B_W'(mag);
            end
            ccl_pkg::MUL_SCALE:
            begin
                op_a = A_W'(sum);
                op_b = B_W'(scale);
            end
            ccl_pkg::MUL_EXP:
            begin
                op_a = A_W'(lg);
                op_b = B_W'(exponent);
            end
            ccl_pkg::MUL_MAG:
            begin
                op_a = A_W'(mag);
                op_b = B_W'(y);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign product = P_W'(op_a) * P_W'(op_b);

endmodule

`default_nettype wire

[rtl/ccl_lzc.sv]
// iterative leading-one normalizer and linear log2 of the denominator,
// one shift step per cycle; depends on ccl_pkg
`default_nettype none

module ccl_lzc (
    input  logic              clk,
    input  logic              rst_n,
    input  ccl_pkg::lz_ctl_t  ctl,
    output ccl_pkg::lz_stat_t stat
);

    localparam int D_W = ccl_pkg::D_W;

    logic [D_W-1:0]                v_reg;
    logic [D_W-1:0]                v_next;
    logic [ccl_pkg::LZ_CNT_W-1:0]  lz_reg;
    logic [ccl_pkg::LZ_CNT_W-1:0]  lz_next;
    logic [ccl_pkg::LZ_STEP_W-1:0] step_reg;

    always_comb
    begin
        v_next  = v_reg;
        lz_next = lz_reg;
        case (step_reg)
            3'd0:
                if (v_reg[D_W-1 -: 16] == '0)
                begin
                    v_next  = v_reg << 16;
                    lz_next = lz_reg + 5'd16;
                end
            3'd1:
                if (v_reg[D_W-1 -: 8] == '0)
                begin
                    v_next  = v_reg << 8;
                    lz_next = lz_reg + 5'd8;
                end
            3'd2:
                if (v_reg[D_W-1 -: 4] == '0)
                begin
                    v_next  = v_reg << 4;
                    lz_next = lz_reg + 5'd4;
                end
            3'd3:
                if (v_reg[D_W-1 -: 2] == '0)
                begin
                    v_next  = v_reg << 2;
                    lz_next = lz_reg + 5'd2;
                end
            3'd4:
                if (!v_reg[D_W-1])
                begin
                    v_next  = v_reg << 1;
                    lz_next = lz_reg + 5'd1;
                end
            default:
            begin
                v_next  = v_reg;
                lz_next = lz_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            lz_reg   <= '0;
            step_reg <= ccl_pkg::LZ_STEP_W'(ccl_pkg::LZ_STEPS);
        end
        else if (ctl.load)
        begin
            v_reg    <= ctl.d;
            lz_reg   <= '0;
            step_reg <= '0;
        end
        else if (step_reg != ccl_pkg::LZ_STEP_W'(ccl_pkg::LZ_STEPS))
        begin
            v_reg    <= v_next;
            lz_reg   <= lz_next;
            step_reg <= step_reg + 3'd1;
        end
    end

    // leading one sits at bit D_W-1-lz; integer part of log2 is that minus 32
    assign stat.done = (step_reg == ccl_pkg::LZ_STEP_W'(ccl_pkg::LZ_STEPS));
    assign stat.lg   = {ccl_pkg::LG_INT_W'(D_W - 1 - ccl_pkg::D_ONE_POS) - lz_reg,
                        v_reg[D_W-2 -: ccl_pkg::FRAC_W]};

endmodule

`default_nettype wire

[rtl/cross_channel_lrn_forward_core.sv]
// top level: cross-channel local response normalization, forward pass
// depends on ccl_pkg, ccl_cfg_if, ccl_feed_if, ccl_result_if, ccl_mul_unit, ccl_lzc
//
//   channel  dir  beat contents
//   cfg      in   index, data (window_size, scale_per_window, exponent)
//   feed     in   sample, last_channel
//   result   out  normalized, last
//
// one sequencer drives a shared multiplier and an iterative normalizer.
// a sample with a result goes through sub (once the window is full), add,
// decide, scale, the normalizer steps, exp, y and mag; a sample without one
// ends after decide; a flushed result first sums its window channel by channel.
// feed.ready is high only while the sequencer is idle; a finished beat sits
// in the result register, so a stalled sink holds the sequencer only when a
// further result is ready. reset restores the register defaults and an empty
// pixel; cfg is taken only while the sequencer is idle, ahead of a feed beat.
`default_nettype none

module cross_channel_lrn_forward_core #(
    parameter int MAX_WINDOW  = ccl_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = ccl_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ccl_cfg_if.sink       cfg,
    ccl_feed_if.sink      feed,
    ccl_result_if.source  result
);

    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CAP  = (MAX_WINDOW - 1) | 1;
    localparam int WC_W = (CW > ccl_pkg::WS_W) ? CW : ccl_pkg::WS_W;
    localparam int A_W  = (SAMPLE_BITS > ccl_pkg::SUM_W) ? SAMPLE_BITS : ccl_pkg::SUM_W;
    localparam int B_W  = (SAMPLE_BITS > ccl_pkg::Y_W) ? SAMPLE_BITS : ccl_pkg::Y_W;
    localparam int P_W  = A_W + B_W;
    localparam int SUM_W = ccl_pkg::SUM_W;
    localparam int FRAC_W = ccl_pkg::FRAC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_DECIDE,
        ST_FL_INIT,
        ST_FL_START,
        ST_ACC,
        ST_SCALE,
        ST_LZ,
        ST_EXP,
        ST_Y,
        ST_MAG
    } state_t;

    state_t                          state_reg;
    logic [ccl_pkg::WS_W-1:0]        ws_reg;
    logic [ccl_pkg::SCALE_W-1:0]     scale_reg;
    logic [ccl_pkg::EXP_W-1:0]       exp_reg;
    logic [CW-1:0]                   seen_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [SUM_W-1:0]                acc_reg;
    logic [CW-1:0]                   norm_idx_reg;
    logic [CW-1:0]                   k_reg;
    logic [CW-1:0]                   j_reg;
    logic [CW-1:0]                   top_reg;
    logic                            flush_reg;
    logic                            emit_last_reg;
    logic                            last_reg;
    logic                            out_valid_reg;
    logic                            out_last_reg;
    logic signed [SAMPLE_BITS-1:0]   out_sample_reg;
    logic signed [SAMPLE_BITS-1:0]   x_reg;
    logic [ccl_pkg::T_W-1:0]         t_reg;
    logic [ccl_pkg::Y_W-1:0]         y_reg;
    logic signed [SAMPLE_BITS-1:0]   win_reg [MAX_WINDOW];

    logic [ccl_pkg::WS_W-1:0]        ws_odd;
    logic [WC_W-1:0]                 ws_wide;
    logic [CW-1:0]                   w_eff;
    logic [CW-1:0]                   h;
    logic [CW-1:0]                   seen_inc;
    logic [CW-1:0]                   pend;
    logic [CW-1:0]                   c_idx;
    logic [CW-1:0]                   top_cand;
    logic [CW-1:0]                   n_m1;
    logic [CW-1:0]                   top_sel;
    logic [CW-1:0]                   rd_idx;
    logic signed [SAMPLE_BITS-1:0]   win_rd;
    logic signed [SAMPLE_BITS-1:0]   mul_sample;
    ccl_pkg::mul_op_t                mul_op;
    logic [P_W-1:0]                  product;
    logic [SUM_W-1:0]                square;
    logic [ccl_pkg::D_W-1:0]         d_val;
    logic [ccl_pkg::Y_W-1:0]         y_base;
    logic [ccl_pkg::Y_W-1:0]         y_val;
    logic [SAMPLE_BITS-1:0]          mag_r;
    logic signed [SAMPLE_BITS-1:0]   signed_r;
    logic                            slot_free;
    ccl_pkg::lz_ctl_t                lz_ctl;
    ccl_pkg::lz_stat_t               lz_stat;

    assign ws_odd  = {ws_reg[ccl_pkg::WS_W-1:1], 1'b1};
    assign ws_wide = WC_W'(ws_odd);
    assign w_eff   = (ws_wide > WC_W'(CAP)) ? CW'(CAP) : CW'(ws_wide);
    assign h       = w_eff >> 1;

    assign seen_inc = (seen_reg < CW'(MAX_WINDOW)) ? seen_reg + CW'(1) : seen_reg;
    assign pend     = (seen_reg < h) ? seen_reg : h;
    assign c_idx    = k_reg - CW'(1);
    assign top_cand = c_idx + h;
    assign n_m1     = seen_reg - CW'(1);
    assign top_sel  = (top_cand > n_m1) ? n_m1 : top_cand;

    always_comb
    begin
        case (state_reg)
            ST_SUB:  rd_idx = w_eff - CW'(1);
            ST_ACC:  rd_idx = j_reg;
            default: rd_idx = norm_idx_reg;
        endcase
    end

    assign win_rd     = win_reg[rd_idx[IW-1:0]];
    assign mul_sample = (state_reg == ST_ADD) ? x_reg : win_rd;

    always_comb
    begin
        case (state_reg)
            ST_SCALE: mul_op = ccl_pkg::MUL_SCALE;
            ST_EXP:   mul_op = ccl_pkg::MUL_EXP;
            ST_MAG:   mul_op = ccl_pkg::MUL_MAG;
            default:  mul_op = ccl_pkg::MUL_SQUARE;
        endcase
    end

    ccl_mul_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mul (
        .op       (mul_op),
        .sample   (mul_sample),
        .sum      (acc_reg),
        .scale    (scale_reg),
        .exponent (exp_reg),
        .lg       (lz_stat.lg),
        .y        (y_reg),
        .product  (product)
    );

    assign square = product[SUM_W-1:0];
    assign d_val  = {1'b0, product[ccl_pkg::D_W-2:0]}
                    + (ccl_pkg::D_W'(1) << ccl_pkg::D_ONE_POS);

    assign lz_ctl.load = (state_reg == ST_SCALE);
    assign lz_ctl.d    = d_val;

    ccl_lzc u_lzc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lz_ctl),
        .stat  (lz_stat)
    );

    // exp2 of minus t: linear mantissa, then shift by the integer part
    assign y_base = {1'b1, {FRAC_W{1'b0}}} - {2'b00, t_reg[FRAC_W-1:1]};
    assign y_val  = (t_reg[ccl_pkg::T_W-1:FRAC_W] >= ccl_pkg::TI_W'(ccl_pkg::Y_ZERO_SHIFT))
                    ? '0 : (y_base >> t_reg[FRAC_W +: ccl_pkg::Y_SHIFT_W]);

    assign mag_r    = product[FRAC_W +: SAMPLE_BITS];
    assign signed_r = win_rd[SAMPLE_BITS-1] ? SAMPLE_BITS'(-mag_r) : SAMPLE_BITS'(mag_r);

    assign slot_free = !out_valid_reg || result.ready;

    assign feed.ready        = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg.ready         = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.normalized = out_sample_reg;
    assign result.last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= ccl_pkg::WS_W'(ccl_pkg::WS_RESET);
            scale_reg     <= ccl_pkg::SCALE_W'(ccl_pkg::SCALE_RESET);
            exp_reg       <= ccl_pkg::EXP_W'(ccl_pkg::EXP_RESET);
            seen_reg      <= '0;
            sum_reg       <= '0;
            acc_reg       <= '0;
            norm_idx_reg  <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            top_reg       <= '0;
            flush_reg     <= 1'b0;
            emit_last_reg <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (result.ready && !(state_reg == ST_MAG && slot_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                    if (feed.valid && feed.ready)
                    begin
                        last_reg  <= feed.last_channel;
                        state_reg <= (seen_reg >= w_eff) ? ST_SUB : ST_ADD;
                    end
                ST_SUB:
                begin
                    sum_reg   <= sum_reg - square;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    sum_reg   <= sum_reg + square;
                    seen_reg  <= seen_inc;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                    if (seen_reg > h)
                    begin
                        acc_reg       <= sum_reg;
                        norm_idx_reg  <= h;
                        flush_reg     <= 1'b0;
                        emit_last_reg <= last_reg && (h == '0);
                        state_reg     <= ST_SCALE;
                    end
                    else if (last_reg)
                    begin
                        state_reg <= ST_FL_INIT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                ST_FL_INIT:
                begin
                    k_reg     <= pend;
                    state_reg <= ST_FL_START;
                end
                ST_FL_START:
                    if (k_reg == '0)
                    begin
                        seen_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        j_reg         <= '0;
                        acc_reg       <= '0;
                        top_reg       <= top_sel;
                        norm_idx_reg  <= c_idx;
                        emit_last_reg <= (k_reg == CW'(1));
                        flush_reg     <= 1'b1;
                        state_reg     <= ST_ACC;
                    end
                ST_ACC:
                begin
                    acc_reg <= acc_reg + square;
                    if (j_reg == top_reg)
                    begin
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                ST_SCALE:
                    state_reg <= ST_LZ;
                ST_LZ:
                    if (lz_stat.done)
                    begin
                        state_reg <= ST_EXP;
                    end
                ST_EXP:
                    state_reg <= ST_Y;
                ST_Y:
                    state_reg <= ST_MAG;
                ST_MAG:
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= emit_last_reg;
                        if (flush_reg)
                        begin
                            k_reg     <= k_reg - CW'(1);
                            state_reg <= ST_FL_START;
                        end
                        else if (last_reg)
                        begin
                            state_reg <= ST_FL_INIT;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    ccl_pkg::REG_WINDOW_SIZE:
                    begin
                        ws_reg   <= cfg.data[ccl_pkg::WS_W-1:0];
                        seen_reg <= '0;
                        sum_reg  <= '0;
                    end
                    ccl_pkg::REG_SCALE:
                        scale_reg <= cfg.data[ccl_pkg::SCALE_W-1:0];
                    ccl_pkg::REG_EXPONENT:
                        exp_reg <= cfg.data[ccl_pkg::EXP_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (feed.valid && feed.ready)
        begin
            x_reg <= feed.sample;
        end
        if (state_reg == ST_ADD)
        begin
            win_reg[0] <= x_reg;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
        if (state_reg == ST_EXP)
        begin
            t_reg <= product[ccl_pkg::T_SHIFT +: ccl_pkg::T_W];
        end
        if (state_reg == ST_Y)
        begin
            y_reg <= y_val;
        end
        if (state_reg == ST_MAG && slot_free)
        begin
            out_sample_reg <= signed_r;
        end
    end

endmodule

`default_nettype wire
